### rtl/core/integer_to_ascii_radix_assert.svh
// ----------------------------------------------------------------------------
// Integer to text converter: assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// condition implies property in the same cycle
`define ITAR_ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// condition implies property in the next cycle
`define ITAR_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### rtl/core/itar_pkg.sv
// ----------------------------------------------------------------------------
// Integer to text converter: shared package
// Widths, character codes, queue entry type and the back-end state type.
// ----------------------------------------------------------------------------
package itar_pkg;

	localparam int WORD_W     = 32;
	localparam int MAX_DIGITS = 32;
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 8;
	localparam int QDEPTH     = 2;

	localparam int BIT_CNT_W = $clog2(WORD_W);
	localparam int NDIG_W    = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W     = $clog2(MAX_DIGITS);
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOWA  = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

	typedef struct packed {
		logic [WORD_W-1:0]  mag;
		logic               neg;
		logic [RADIX_W-1:0] base;
	} itar_cmd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CONV,
		B_EMIT
	} itar_back_state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < RADIX_DEC) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_LOWA + CHAR_W'(d - RADIX_DEC);
		end
		return c;
	endfunction

endpackage

### rtl/core/itar_in_if.sv
// ----------------------------------------------------------------------------
// Integer to text converter: input channel
// Valid/ready channel carrying one signed 32-bit number per transfer.
// ----------------------------------------------------------------------------
interface itar_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

### rtl/core/itar_out_if.sv
// ----------------------------------------------------------------------------
// Integer to text converter: output channel
// Valid/ready channel carrying one ASCII character and a last flag per transfer.
// ----------------------------------------------------------------------------
interface itar_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       last_char;

	modport source (output valid, output text_char, output last_char, input ready);
	modport sink (input valid, input text_char, input last_char, output ready);
endinterface

### rtl/core/itar_front.sv
// ----------------------------------------------------------------------------
// Integer to text converter: front end
// Holds the radix register, clamps it, takes the sign (in base 10 only) and
// magnitude of each number and pushes a command into the queue.
// ----------------------------------------------------------------------------
module itar_front
	import itar_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [RADIX_W-1:0]  cfg_wdata,
	itar_in_if.sink             number_ch,
	output logic                push_valid,
	input  logic                push_ready,
	output itar_cmd_t           push_cmd
);

	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] base_eff;
	logic               neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base_eff = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base_eff = RADIX_MAX;
		end else begin
			base_eff = radix_q;
		end
	end

	assign neg = number_ch.number[WORD_W-1] && (base_eff == RADIX_DEC);

	assign push_valid      = number_ch.valid;
	assign number_ch.ready = push_ready;
	assign push_cmd.neg    = neg;
	assign push_cmd.base   = base_eff;
	assign push_cmd.mag    = neg ? (WORD_W'(0) - WORD_W'(number_ch.number))
	                             : WORD_W'(number_ch.number);

endmodule

### rtl/core/itar_queue.sv
// ----------------------------------------------------------------------------
// Integer to text converter: command queue
// Short FIFO between front and back end.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_assert.svh"

module itar_queue
	import itar_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  itar_cmd_t  push_cmd,
	output logic       pop_valid,
	input  logic       pop,
	output itar_cmd_t  pop_cmd
);

	itar_cmd_t          entry_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               push;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	`ITAR_ASSERT_IMPL(a_q_cnt_max, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "queue count overflow")
	`ITAR_ASSERT_IMPL(a_q_pop_empty, pop, cnt_q != '0, "pop from empty queue")
	`ITAR_ASSERT_NEXT(a_q_push_cnt, push && !pop, cnt_q != '0, "push lost")

endmodule

### rtl/core/itar_back.sv
// ----------------------------------------------------------------------------
// Integer to text converter: back end
// Shift-and-add radix conversion, one input bit per cycle, then emission
// of sign and digits through an output register.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_assert.svh"

module itar_back
	import itar_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop,
	input  itar_cmd_t  pop_cmd,
	itar_out_if.source text_ch
);

	itar_back_state_t state_q, state_n;

	logic [WORD_W-1:0]    val_q;
	logic [RADIX_W-1:0]   base_q;
	logic                 sign_q;
	logic [RADIX_W-1:0]   digit_q [MAX_DIGITS];
	logic [RADIX_W-1:0]   digit_n [MAX_DIGITS];
	logic [NDIG_W-1:0]    ndig_q;
	logic [NDIG_W-1:0]    ndig_n;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [IDX_W-1:0]     idx_q;

	logic                 ov_q;
	logic [CHAR_W-1:0]    oc_q;
	logic                 ol_q;

	logic [MAX_DIGITS-1:0] gen;
	logic [MAX_DIGITS-1:0] gp;
	logic [MAX_DIGITS:0]   sum;
	logic [MAX_DIGITS:0]   carry;
	logic                  conv_done;
	logic                  emit_fire;
	logic                  emit_last;
	logic [CHAR_W-1:0]     emit_char;

	// carry into each digit from a generate/propagate add
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			gen[i] = {digit_q[i], 1'b0} >= {1'b0, base_q};
			gp[i]  = gen[i] || ({digit_q[i], 1'b1} == {1'b0, base_q});
		end
		sum   = {1'b0, gen} + {1'b0, gp} + (MAX_DIGITS + 1)'(val_q[WORD_W-1]);
		carry = sum ^ {1'b0, gen} ^ {1'b0, gp};
		for (int i = 0; i < MAX_DIGITS; i++) begin
			digit_n[i] = RADIX_W'({digit_q[i], 1'b0} + (RADIX_W + 1)'(carry[i])
			             - (carry[i+1] ? {1'b0, base_q} : (RADIX_W + 1)'(0)));
		end
		if (ndig_q != NDIG_W'(MAX_DIGITS) && carry[ndig_q]) begin
			ndig_n = ndig_q + 1'b1;
		end else begin
			ndig_n = ndig_q;
		end
	end

	assign conv_done = (bit_cnt_q == BIT_CNT_W'(WORD_W - 1));

	always_comb begin
		pop       = (state_q == B_IDLE) && pop_valid;
		emit_fire = (state_q == B_EMIT) && (!ov_q || text_ch.ready);
		emit_last = !sign_q && ((ndig_q == '0) || (idx_q == '0));
		if (sign_q) begin
			emit_char = CHAR_MINUS;
		end else if (ndig_q == '0) begin
			emit_char = CHAR_ZERO;
		end else begin
			emit_char = digit_char(digit_q[idx_q]);
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					state_n = B_CONV;
				end
			end
			B_CONV: begin
				if (conv_done) begin
					state_n = B_EMIT;
				end
			end
			B_EMIT: begin
				if (emit_fire && emit_last) begin
					state_n = B_IDLE;
				end
			end
			default: begin
				state_n = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (emit_fire) begin
				ov_q <= 1'b1;
			end else if (text_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			val_q     <= pop_cmd.mag;
			base_q    <= pop_cmd.base;
			sign_q    <= pop_cmd.neg;
			ndig_q    <= '0;
			bit_cnt_q <= '0;
			for (int i = 0; i < MAX_DIGITS; i++) begin
				digit_q[i] <= '0;
			end
		end
		if (state_q == B_CONV) begin
			val_q     <= val_q << 1;
			ndig_q    <= ndig_n;
			bit_cnt_q <= bit_cnt_q + 1'b1;
			for (int i = 0; i < MAX_DIGITS; i++) begin
				digit_q[i] <= digit_n[i];
			end
			if (conv_done) begin
				idx_q <= IDX_W'(ndig_n - 1'b1);
			end
		end
		if (emit_fire) begin
			oc_q <= emit_char;
			ol_q <= emit_last;
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	assign text_ch.valid     = ov_q;
	assign text_ch.text_char = oc_q;
	assign text_ch.last_char = ol_q;

	`ITAR_ASSERT_IMPL(a_b_pop_idle, pop, state_q == B_IDLE, "pop outside idle")
	`ITAR_ASSERT_IMPL(a_b_ndig_bits, state_q == B_CONV,
		NDIG_W'(bit_cnt_q) >= ndig_q, "more digits than bits consumed")
	`ITAR_ASSERT_IMPL(a_b_idx_range, (state_q == B_EMIT) && !sign_q && (ndig_q != '0),
		NDIG_W'(idx_q) < ndig_q, "digit index beyond digit count")

endmodule

### rtl/core/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// Integer to text converter: top level
// Turns each signed 32-bit number into ASCII text in the configured base.
// ----------------------------------------------------------------------------
// Each number transferred on number_ch comes out on text_ch as its characters,
// most significant first, last_char set on the final one; zero gives "0".
// In base 10 a negative number gets a leading '-' and its magnitude, in any
// other base the 32 bits are read as unsigned; digits above 9 are 'a'..'z'.
// cfg_we/cfg_wdata write the radix (reset 10, clamped to 2..36 when used);
// the user must write them only while the block is idle, which the block
// itself does not enforce. A number leaves the queue, passes the bit-serial
// conversion (one input bit per cycle through the digit array, 32 bits) and
// is then emitted as 1 to 32 characters. A two-entry queue lets further
// numbers be accepted while the back end converts and emits.
module integer_to_ascii_radix
	import itar_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [RADIX_W-1:0] cfg_wdata,
	itar_in_if.sink            number_ch,
	itar_out_if.source         text_ch
);

	logic      push_valid;
	logic      push_ready;
	itar_cmd_t push_cmd;
	logic      pop_valid;
	logic      pop;
	itar_cmd_t pop_cmd;

	itar_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.number_ch  (number_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	itar_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	itar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.text_ch   (text_ch)
	);

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer to text converter: testbench
// Sends numbers under a range of radix settings, with random gaps on the
// input and random back-pressure on the output. A scoreboard predicts the
// characters for each number and compares every character transfer in order.
// ----------------------------------------------------------------------------
module testbench;
	import itar_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [CHAR_W-1:0] text_char;
		logic              last_char;
	} text_beat_t;

	class text_scoreboard;
		logic [RADIX_W-1:0] radix_reg;
		text_beat_t         pending_chars[$];
		int                 errors;

		function new();
			radix_reg = RADIX_RESET;
			errors = 0;
		endfunction

		// Spell one accepted number out into the queue of expected characters.
		function void note_number(logic [WORD_W-1:0] raw);
			logic [WORD_W-1:0] base;
			logic [WORD_W-1:0] mag;
			logic [WORD_W-1:0] d;
			logic [CHAR_W-1:0] digits[$];
			bit                neg;
			base = WORD_W'(radix_reg);
			if (radix_reg < RADIX_MIN) begin
				base = WORD_W'(RADIX_MIN);
			end else if (radix_reg > RADIX_MAX) begin
				base = WORD_W'(RADIX_MAX);
			end
			if (raw == '0) begin
				pending_chars.push_back('{CHAR_ZERO, 1'b1});
				return;
			end
			neg = raw[WORD_W-1] && (base == WORD_W'(RADIX_DEC));
			mag = neg ? (WORD_W'(0) - raw) : raw;
			while (mag != '0) begin
				d = mag % base;
				if (d < 10) begin
					digits.push_back(CHAR_ZERO + CHAR_W'(d));
				end else begin
					digits.push_back(CHAR_LOWA + CHAR_W'(d - 10));
				end
				mag = mag / base;
			end
			if (neg) begin
				pending_chars.push_back('{CHAR_MINUS, digits.size() == 0});
			end
			for (int i = digits.size() - 1; i >= 0; i--) begin
				pending_chars.push_back('{digits[i], i == 0});
			end
		endfunction

		function void check_char(logic [CHAR_W-1:0] ch, logic last);
			text_beat_t want;
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected transfer, got char %h last %b", $time, ch, last);
				errors++;
				return;
			end
			want = pending_chars.pop_front();
			if (ch !== want.text_char) begin
				$display("%0t: text_char mismatch, expected %h got %h",
					$time, want.text_char, ch);
				errors++;
			end
			if (last !== want.last_char) begin
				$display("%0t: last_char mismatch, expected %b got %b",
					$time, want.last_char, last);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [RADIX_W-1:0] cfg_wdata;
	int unsigned        cycles;
	text_scoreboard     sb;

	itar_in_if  number_ch();
	itar_out_if text_ch();

	integer_to_ascii_radix uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.number_ch (number_ch),
		.text_ch   (text_ch)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		number_ch.valid = 1'b0;
		number_ch.number = '0;
		text_ch.ready = 1'b0;
		cycles = 0;
		sb = new();
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && text_ch.valid && text_ch.ready) begin
			sb.check_char(text_ch.text_char, text_ch.last_char);
		end
	end

	// Output back-pressure: runs of ready, short stalls and the odd long one.
	initial begin
		int hold;
		int r;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					text_ch.ready <= 1'b1;
					hold = $urandom_range(60, 200);
				end else if (r < 55) begin
					text_ch.ready <= 1'b1;
					hold = $urandom_range(0, 20);
				end else if (r < 93) begin
					text_ch.ready <= 1'b0;
					hold = $urandom_range(0, 3);
				end else begin
					text_ch.ready <= 1'b0;
					hold = $urandom_range(10, 40);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [WORD_W-1:0] pick_number(logic [RADIX_W-1:0] radix);
		longint unsigned p;
		int              base;
		int              r;
		int              k;
		base = radix < RADIX_MIN ? 2 : (radix > RADIX_MAX ? 36 : int'(radix));
		r = $urandom_range(0, 99);
		if (r < 35) begin
			return $urandom;
		end else if (r < 50) begin
			return $urandom_range(0, 1000);
		end else if (r < 60) begin
			return WORD_W'(0) - $urandom_range(1, 1000);
		end else if (r < 67) begin
			return '0;
		end else if (r < 80) begin
			p = 1;
			k = $urandom_range(1, 31);
			repeat (k) begin
				if (p * base < 64'h1_0000_0000) begin
					p = p * base;
				end
			end
			return WORD_W'(p + $urandom_range(0, 2) - 1);
		end else if (r < 88) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'hffff_ffff;
				default: return 32'h0000_0001;
			endcase
		end
		p = $urandom >> $urandom_range(0, 31);
		return ($urandom_range(0, 1) == 1) ? WORD_W'(0) - WORD_W'(p) : WORD_W'(p);
	endfunction

	task automatic send_number(input logic [WORD_W-1:0] n, input bit gapless);
		int gap;
		gap = gapless ? 0 : pick_gap();
		if (gap > 0) begin
			number_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.number <= n;
		do @(posedge clk); while (!number_ch.ready);
		sb.note_number(n);
	endtask

	task automatic wait_drained();
		number_ch.valid <= 1'b0;
		while (sb.pending_chars.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.radix_reg = value;
	endtask

	initial begin
		logic [RADIX_W-1:0] phase_radix[8];
		logic [RADIX_W-1:0] radix;
		bit                 gapless;
		phase_radix = '{6'd2, 6'd36, 6'd10, 6'd0, 6'd63, 6'd16, 6'd37, 6'd1};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset radix: decimal, signs, extremes
		send_number(32'd0, 1'b0);
		send_number(32'd1, 1'b0);
		send_number(32'hffff_ffff, 1'b1);
		send_number(32'h7fff_ffff, 1'b0);
		send_number(32'h8000_0000, 1'b0);
		send_number(32'd9, 1'b1);
		send_number(32'd10, 1'b0);
		send_number(32'd123456789, 1'b0);
		send_number(-32'sd987654321, 1'b1);
		wait_drained();

		write_radix(6'd2);
		send_number(32'h8000_0000, 1'b0);
		send_number(32'hffff_ffff, 1'b1);
		send_number(32'd1, 1'b0);
		send_number(32'd5, 1'b0);
		wait_drained();

		write_radix(6'd36);
		send_number(32'd35, 1'b0);
		send_number(32'd36, 1'b1);
		send_number(32'hffff_ffff, 1'b0);
		send_number(32'h7fff_ffff, 1'b0);
		wait_drained();

		write_radix(6'd16);
		send_number(32'hdead_beef, 1'b0);
		send_number(32'd10, 1'b0);
		wait_drained();

		// out-of-range settings are clamped to 2 and 36
		write_radix(6'd0);
		send_number(32'd6, 1'b0);
		wait_drained();
		write_radix(6'd63);
		send_number(32'd71, 1'b0);
		wait_drained();

		for (int ph = 0; ph < 12; ph++) begin
			radix = (ph < 8) ? phase_radix[ph] : RADIX_W'($urandom_range(0, 63));
			write_radix(radix);
			gapless = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 38; i++) begin
				if ((ph == 0 && i == 19) || $urandom_range(0, 99) < 3) begin
					wait_drained();
				end
				send_number(pick_number(radix), gapless);
			end
			wait_drained();
		end

		repeat (70) @(posedge clk);
		if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
